@@ sv/skf_pkg.sv @@
// ---------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and codes for the scalar Kalman filter.
// ---------------------------------------------------------------------------
package skf_pkg;

   // Field and arithmetic widths
   localparam int SAMPLE_BITS    = 12;
   localparam int GAIN_FRAC_BITS = 24;
   localparam int EST_BITS       = 28;
   localparam int EST_FRAC       = 16;
   localparam int VAR_BITS       = 32;
   localparam int GAIN_OUT_BITS  = 25;
   localparam int DIV_STEPS      = GAIN_FRAC_BITS + 1;
   localparam int CNT_BITS       = $clog2(DIV_STEPS);
   localparam int REQ_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((EST_BITS + GAIN_OUT_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic [SAMPLE_BITS-1:0]             smp_type;
   typedef logic [REQ_DATA_BITS-1:0]           req_data_type;
   typedef logic [RSP_DATA_BITS-1:0]           rsp_data_type;
   typedef logic [VAR_BITS-1:0]                var_type;
   typedef logic [VAR_BITS:0]                  den_type;
   typedef logic [VAR_BITS+1:0]                rem_type;
   typedef logic [EST_BITS-1:0]                est_type;
   typedef logic [EST_BITS:0]                  est_sum_type;
   typedef logic [SAMPLE_BITS+EST_FRAC-1:0]    meas_type;
   typedef logic [GAIN_FRAC_BITS:0]            gain_type;
   typedef logic [GAIN_OUT_BITS-1:0]           gain_out_type;
   typedef logic [GAIN_FRAC_BITS+VAR_BITS:0]   prod_type;
   typedef logic [VAR_BITS:0]                  delta_type;
   typedef logic [VAR_BITS+1:0]                xsum_type;
   typedef logic [CNT_BITS-1:0]                cnt_type;
   typedef logic [CSR_ADDR_BITS-1:0]           csr_addr_type;
   typedef logic [CSR_DATA_BITS-1:0]           csr_data_type;

   localparam gain_type GAIN_ONE   = gain_type'(1) << GAIN_FRAC_BITS;
   localparam prod_type ROUND_UP   = (prod_type'(1) << GAIN_FRAC_BITS) - prod_type'(1);
   localparam est_type  EST_MAX    = '1;
   localparam var_type  VAR_MAX    = '1;
   localparam cnt_type  CNT_LAST   = cnt_type'(DIV_STEPS - 1);

   // Register reset values
   localparam var_type Q_RESET  = var_type'(168);
   localparam var_type R_RESET  = var_type'(167772160);
   localparam var_type P0_RESET = var_type'(16777216);
   localparam est_type X0_RESET = est_type'(0);

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_DRIFT_VAR         = 2'd0,
      REG_SENSOR_VAR        = 2'd1,
      REG_INITIAL_VARIANCE  = 2'd2,
      REG_INITIAL_ESTIMATE  = 2'd3
   } reg_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRED,
      ST_DEN,
      ST_DIV,
      ST_MUL_X,
      ST_UPD_X,
      ST_MUL_P,
      ST_UPD_P,
      ST_DONE
   } state_type;

   // Configuration seen by the datapath
   typedef struct packed {
      var_type q;
      var_type r;
      var_type p0;
      est_type x0;
   } cfg_type;

   // Sequencer strobes to the datapath
   typedef struct packed {
      logic accept;
      logic pred;
      logic den;
      logic div_step;
      logic div_first;
      logic mul_x;
      logic upd_x;
      logic mul_p;
      logic upd_p;
      logic out_load;
   } ctl_type;

endpackage

@@ sv/skf_csr.sv @@
// ---------------------------------------------------------------------------
// skf_csr
// APB-style register file: noise variances and initial state values.
// ---------------------------------------------------------------------------
module skf_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  skf_pkg::csr_addr_type csr_paddr,
   input  skf_pkg::csr_data_type csr_pwdata,
   output skf_pkg::csr_data_type csr_prdata,
   output logic                  csr_pready,
   output skf_pkg::cfg_type      cfg
);

   skf_pkg::cfg_type       cfg_ff;
   skf_pkg::cfg_type       cfg_in;
   skf_pkg::reg_index_type index;
   logic                   wr_en;

   assign index      = skf_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            skf_pkg::REG_DRIFT_VAR:         cfg_in.q  = csr_pwdata;
            skf_pkg::REG_SENSOR_VAR:        cfg_in.r  = csr_pwdata;
            skf_pkg::REG_INITIAL_VARIANCE:  cfg_in.p0 = csr_pwdata;
            skf_pkg::REG_INITIAL_ESTIMATE:  cfg_in.x0 = csr_pwdata[skf_pkg::EST_BITS-1:0];
            default:                        cfg_in    = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.q  <= skf_pkg::Q_RESET;
         cfg_ff.r  <= skf_pkg::R_RESET;
         cfg_ff.p0 <= skf_pkg::P0_RESET;
         cfg_ff.x0 <= skf_pkg::X0_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         skf_pkg::REG_DRIFT_VAR:         csr_prdata = cfg_ff.q;
         skf_pkg::REG_SENSOR_VAR:        csr_prdata = cfg_ff.r;
         skf_pkg::REG_INITIAL_VARIANCE:  csr_prdata = cfg_ff.p0;
         skf_pkg::REG_INITIAL_ESTIMATE:  csr_prdata = skf_pkg::csr_data_type'(cfg_ff.x0);
         default:                        csr_prdata = '0;
      endcase
   end

endmodule

@@ sv/skf_ctrl.sv @@
// ---------------------------------------------------------------------------
// skf_ctrl
// Sequencer: steps one sample through prediction, division and updates.
// ---------------------------------------------------------------------------
module skf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output skf_pkg::ctl_type ctl
);

   skf_pkg::state_type state_ff;
   skf_pkg::state_type state_in;
   skf_pkg::cnt_type   cnt_ff;
   skf_pkg::cnt_type   cnt_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               slot_free;

   assign slot_free  = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skf_pkg::ST_IDLE:  if (req_tvalid) state_in = skf_pkg::ST_PRED;
         skf_pkg::ST_PRED:  state_in = skf_pkg::ST_DEN;
         skf_pkg::ST_DEN:   state_in = skf_pkg::ST_DIV;
         skf_pkg::ST_DIV:   if (cnt_ff == skf_pkg::CNT_LAST) state_in = skf_pkg::ST_MUL_X;
         skf_pkg::ST_MUL_X: state_in = skf_pkg::ST_UPD_X;
         skf_pkg::ST_UPD_X: state_in = skf_pkg::ST_MUL_P;
         skf_pkg::ST_MUL_P: state_in = skf_pkg::ST_UPD_P;
         skf_pkg::ST_UPD_P: state_in = skf_pkg::ST_DONE;
         skf_pkg::ST_DONE:  if (slot_free) state_in = skf_pkg::ST_IDLE;
         default:           state_in = skf_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         skf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ctl.accept = req_tvalid;
         end
         skf_pkg::ST_PRED:  ctl.pred = 1'b1;
         skf_pkg::ST_DEN:   ctl.den  = 1'b1;
         skf_pkg::ST_DIV: begin
            ctl.div_step  = 1'b1;
            ctl.div_first = (cnt_ff == '0);
         end
         skf_pkg::ST_MUL_X: ctl.mul_x    = 1'b1;
         skf_pkg::ST_UPD_X: ctl.upd_x    = 1'b1;
         skf_pkg::ST_MUL_P: ctl.mul_p    = 1'b1;
         skf_pkg::ST_UPD_P: ctl.upd_p    = 1'b1;
         skf_pkg::ST_DONE:  ctl.out_load = slot_free;
         default:           ctl          = '0;
      endcase
   end

   // Step counter and result valid
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == skf_pkg::ST_DEN) begin
         cnt_in = '0;
      end else if (state_ff == skf_pkg::ST_DIV) begin
         cnt_in = cnt_ff + skf_pkg::cnt_type'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/skf_dp.sv @@
// ---------------------------------------------------------------------------
// skf_dp
// Datapath: filter state, restoring divider and one shared multiplier.
// ---------------------------------------------------------------------------
module skf_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  skf_pkg::ctl_type      ctl,
   input  skf_pkg::cfg_type      cfg,
   input  skf_pkg::smp_type      req_sample,
   input  logic                  req_restart,
   output skf_pkg::est_type      rsp_estimate,
   output skf_pkg::gain_out_type rsp_gain
);

   // Filter state (reset to the register reset values)
   skf_pkg::est_type      x_ff,        x_in;
   skf_pkg::var_type      p_ff,        p_in;
   // Working registers
   skf_pkg::smp_type      smp_ff;
   skf_pkg::var_type      p1_ff;
   skf_pkg::den_type      den_ff;
   logic                  den_zero_ff;
   skf_pkg::rem_type      rem_ff,      rem_in;
   skf_pkg::gain_type     quo_ff;
   skf_pkg::est_type      mag_ff;
   logic                  neg_ff;
   skf_pkg::prod_type     prod_ff;
   skf_pkg::est_type      est_out_ff;
   skf_pkg::gain_out_type gain_out_ff;

   skf_pkg::den_type      p_sum;
   skf_pkg::meas_type     meas_full;
   skf_pkg::est_type      meas;
   skf_pkg::rem_type      trial;
   logic                  ge;
   skf_pkg::gain_type     gain;
   skf_pkg::gain_type     mul_a;
   skf_pkg::var_type      mul_b;
   skf_pkg::prod_type     rnd_prod;
   skf_pkg::delta_type    delta;
   skf_pkg::xsum_type     xsum;

   function automatic skf_pkg::meas_type req_sample_ext(input skf_pkg::smp_type s);
      return skf_pkg::meas_type'(s);
   endfunction

   assign rsp_estimate = est_out_ff;
   assign rsp_gain     = gain_out_ff;

   // Prediction: saturating variance growth and measurement magnitude
   assign p_sum     = skf_pkg::den_type'(p_ff) + skf_pkg::den_type'(cfg.q);
   assign meas_full = skf_pkg::meas_type'(req_sample_ext(smp_ff)) << skf_pkg::EST_FRAC;
   assign meas      = (meas_full > skf_pkg::meas_type'(skf_pkg::EST_MAX)) ?
                      skf_pkg::EST_MAX : skf_pkg::est_type'(meas_full);

   // One restoring division step: compare, subtract, shift in a quotient bit
   assign trial  = ctl.div_first ? rem_ff : (rem_ff << 1);
   assign ge     = (trial >= skf_pkg::rem_type'(den_ff));
   assign rem_in = ge ? (trial - skf_pkg::rem_type'(den_ff)) : trial;
   assign gain   = den_zero_ff ? '0 : quo_ff;

   // Shared multiplier operands
   always_comb begin
      if (ctl.mul_p) begin
         mul_a = skf_pkg::GAIN_ONE - gain;
         mul_b = p1_ff;
      end else begin
         mul_a = gain;
         mul_b = skf_pkg::var_type'(mag_ff);
      end
   end

   // Estimate update: round toward minus infinity, then clamp
   assign rnd_prod = prod_ff + (neg_ff ? skf_pkg::ROUND_UP : '0);
   assign delta    = skf_pkg::delta_type'(rnd_prod >> skf_pkg::GAIN_FRAC_BITS);
   assign xsum     = skf_pkg::xsum_type'(x_ff) + skf_pkg::xsum_type'(delta);

   always_comb begin
      x_in = x_ff;
      p_in = p_ff;
      if (ctl.accept && req_restart) begin
         x_in = cfg.x0;
         p_in = cfg.p0;
      end else if (ctl.upd_x) begin
         if (neg_ff) begin
            x_in = (delta > skf_pkg::delta_type'(x_ff)) ?
                   '0 : skf_pkg::est_type'(skf_pkg::delta_type'(x_ff) - delta);
         end else begin
            x_in = (xsum > skf_pkg::xsum_type'(skf_pkg::EST_MAX)) ?
                   skf_pkg::EST_MAX : skf_pkg::est_type'(xsum);
         end
      end else if (ctl.upd_p) begin
         p_in = skf_pkg::var_type'(prod_ff >> skf_pkg::GAIN_FRAC_BITS);
      end
   end

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= skf_pkg::X0_RESET;
         p_ff <= skf_pkg::P0_RESET;
      end else begin
         x_ff <= x_in;
         p_ff <= p_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         smp_ff <= req_sample;
      end
      if (ctl.pred) begin
         p1_ff  <= p_sum[skf_pkg::VAR_BITS] ? skf_pkg::VAR_MAX :
                   skf_pkg::var_type'(p_sum);
         neg_ff <= (meas < x_ff);
         mag_ff <= (meas < x_ff) ? (x_ff - meas) : (meas - x_ff);
      end
      if (ctl.den) begin
         den_ff      <= skf_pkg::den_type'(p1_ff) + skf_pkg::den_type'(cfg.r);
         den_zero_ff <= (p1_ff == '0) && (cfg.r == '0);
         rem_ff      <= skf_pkg::rem_type'(p1_ff);
      end
      if (ctl.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[skf_pkg::GAIN_FRAC_BITS-1:0], ge};
      end
      if (ctl.mul_x || ctl.mul_p) begin
         prod_ff <= skf_pkg::prod_type'(mul_a) * skf_pkg::prod_type'(mul_b);
      end
      if (ctl.out_load) begin
         est_out_ff  <= x_ff;
         gain_out_ff <= skf_pkg::gain_out_type'(gain);
      end
   end

endmodule

@@ sv/scalar_kalman_filter.sv @@
// ---------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter in fixed point, one sensor sample a transfer.
// ---------------------------------------------------------------------------
//  channel  direction  ports           payload
//  req      in         req_t*          tdata: sample; tuser: restart
//  rsp      out        rsp_t*          tdata: estimate, gain
//  csr      in/out     csr_p*          drift variance, sensor variance,
//                                      initial_variance, initial_estimate
//
//  A sample runs through these steps from one req transfer to the next: accept,
//  prediction and denominator, 25 steps of the restoring gain divider, two passes
//  through the shared multiplier with their updates, and one output load.
//  Reset (synchronous) reloads the registers and the state from their reset
//  values. A result waits in the output register while req is taken again;
//  a stalled rsp holds the sequencer in its last cycle.
// ---------------------------------------------------------------------------
module scalar_kalman_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  skf_pkg::req_data_type req_tdata,   // [11:0] sample
   input  logic                  req_tuser,   // [0] restart
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output skf_pkg::rsp_data_type rsp_tdata,   // [27:0] estimate, [52:28] gain
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  skf_pkg::csr_addr_type csr_paddr,
   input  skf_pkg::csr_data_type csr_pwdata,
   output skf_pkg::csr_data_type csr_prdata,
   output logic                  csr_pready
);

   skf_pkg::cfg_type      cfg;
   skf_pkg::ctl_type      ctl;
   skf_pkg::est_type      rsp_estimate;
   skf_pkg::gain_out_type rsp_gain;

   // Pack the result transfer
   assign rsp_tdata = skf_pkg::rsp_data_type'({rsp_gain, rsp_estimate});

   skf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   skf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   skf_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .cfg          (cfg),
      .req_sample   (req_tdata[skf_pkg::SAMPLE_BITS-1:0]),
      .req_restart  (req_tuser),
      .rsp_estimate (rsp_estimate),
      .rsp_gain     (rsp_gain)
   );

endmodule
